@@ rtl/best_fit_allocator_coalescing_top_assert.svh @@
// Assertion macros shared by the checker of the best-fit allocator.
`ifndef BEST_FIT_ALLOCATOR_COALESCING_TOP_ASSERT_SVH
`define BEST_FIT_ALLOCATOR_COALESCING_TOP_ASSERT_SVH

// Same-cycle implication under the active-low reset.
`define BFA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under the active-low reset.
`define BFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bfa_pkg.sv @@
// Shared constants, types and micro-operation codes of the best-fit allocator.
`timescale 1ns / 1ps
package bfa_pkg;

    localparam int MAX_BLOCKS = 1024;
    localparam int DATA_W     = 32;
    localparam int AW         = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [DATA_W-1:0] start;
        logic [DATA_W-1:0] length;
        logic              used;
        logic [DATA_W-1:0] tag;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [4:0] {
        OP_NOP,
        OP_CFG,
        OP_INIT,
        OP_ACCEPT,
        OP_RD,
        OP_EV,
        OP_EV_RIGHT,
        OP_MERGE,
        OP_SH_DN,
        OP_FREE_END,
        OP_INS_START,
        OP_SH_UP,
        OP_WR_REM,
        OP_WR_HEAD,
        OP_RES_OK,
        OP_RES_NOFIT,
        OP_RES_FULL
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic is_free;
        logic found;
        logic scan_end;
        logic size_zero;
        logic have;
        logic rest_nz;
        logic full;
        logic idx_gt_best;
        logic out_free;
    } stat_t;

endpackage

@@ rtl/best_fit_allocator_coalescing_top.sv @@
// One request at a time: the controller reads and evaluates each table entry
// scanned, then moves entries on a split or merge, all through the table RAM;
// an allocate result waits until the output register is free.
// A free gives no result.
// After reset or a total_cells write, the INIT state rebuilds the single free block.
// Top level of the best-fit allocator with coalescing.
`timescale 1ns / 1ps
module best_fit_allocator_coalescing_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // opcode[0], alloc_size[32:1], release_request[64:33]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // start_address[31:0], status[33:32]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    bfa_pkg::cmd_t  cmd;
    bfa_pkg::stat_t st;
    logic [31:0]    out_start;
    logic [1:0]     out_status;

    bfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .cfg_valid (cfg_valid),
        .st        (st),
        .in_ready  (s_axis_tready),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    bfa_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .cfg_data   (cfg_data),
        .in_opcode  (s_axis_tdata[0]),
        .in_size    (s_axis_tdata[32:1]),
        .in_release (s_axis_tdata[64:33]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_start  (out_start),
        .out_status (out_status)
    );

    assign m_axis_tdata = {6'b0, out_status, out_start};

endmodule

@@ rtl/bfa_ram.sv @@
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module bfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/bfa_ctrl.sv @@
// Controller state machine that sequences scans, shifts and responses.
`timescale 1ns / 1ps
module bfa_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          cfg_valid,
    input  bfa_pkg::stat_t st,
    output logic          in_ready,
    output logic          cfg_ready,
    output bfa_pkg::cmd_t cmd
);

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_SCAN_RD, S_SCAN_EV, S_A_DECIDE, S_INS_RD, S_INS_WR,
        S_WR_REM, S_WR_HEAD, S_R_OK, S_R_NOFIT, S_R_FULL, S_F_RD_R, S_F_EV_R,
        S_F_PLAN, S_SH_RD, S_SH_WR
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cfg_ready = (state_reg == S_IDLE);
    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = bfa_pkg::OP_NOP;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.op     = bfa_pkg::OP_INIT;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    cmd.op     = bfa_pkg::OP_CFG;
                    state_next = S_INIT;
                end
                else if (in_valid)
                begin
                    cmd.op     = bfa_pkg::OP_ACCEPT;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                if (st.is_free && st.found)
                begin
                    state_next = S_F_RD_R;
                end
                else if (st.scan_end)
                begin
                    state_next = st.is_free ? S_IDLE : S_A_DECIDE;
                end
                else
                begin
                    cmd.op     = bfa_pkg::OP_RD;
                    state_next = S_SCAN_EV;
                end
            end
            S_SCAN_EV:
            begin
                cmd.op     = bfa_pkg::OP_EV;
                state_next = S_SCAN_RD;
            end
            S_A_DECIDE:
            begin
                if (st.size_zero || !st.have)
                begin
                    state_next = S_R_NOFIT;
                end
                else if (st.rest_nz && st.full)
                begin
                    state_next = S_R_FULL;
                end
                else if (st.rest_nz)
                begin
                    cmd.op     = bfa_pkg::OP_INS_START;
                    state_next = S_INS_RD;
                end
                else
                begin
                    state_next = S_WR_HEAD;
                end
            end
            S_INS_RD:
            begin
                if (st.idx_gt_best)
                begin
                    cmd.op     = bfa_pkg::OP_RD;
                    state_next = S_INS_WR;
                end
                else
                begin
                    state_next = S_WR_REM;
                end
            end
            S_INS_WR:
            begin
                cmd.op     = bfa_pkg::OP_SH_UP;
                state_next = S_INS_RD;
            end
            S_WR_REM:
            begin
                cmd.op     = bfa_pkg::OP_WR_REM;
                state_next = S_WR_HEAD;
            end
            S_WR_HEAD:
            begin
                cmd.op     = bfa_pkg::OP_WR_HEAD;
                state_next = S_R_OK;
            end
            S_R_OK:
            begin
                if (st.out_free)
                begin
                    cmd.op     = bfa_pkg::OP_RES_OK;
                    state_next = S_IDLE;
                end
            end
            S_R_NOFIT:
            begin
                if (st.out_free)
                begin
                    cmd.op     = bfa_pkg::OP_RES_NOFIT;
                    state_next = S_IDLE;
                end
            end
            S_R_FULL:
            begin
                if (st.out_free)
                begin
                    cmd.op     = bfa_pkg::OP_RES_FULL;
                    state_next = S_IDLE;
                end
            end
            S_F_RD_R:
            begin
                if (!st.scan_end)
                begin
                    cmd.op     = bfa_pkg::OP_RD;
                    state_next = S_F_EV_R;
                end
                else
                begin
                    state_next = S_F_PLAN;
                end
            end
            S_F_EV_R:
            begin
                cmd.op     = bfa_pkg::OP_EV_RIGHT;
                state_next = S_F_PLAN;
            end
            S_F_PLAN:
            begin
                cmd.op     = bfa_pkg::OP_MERGE;
                state_next = S_SH_RD;
            end
            S_SH_RD:
            begin
                if (!st.scan_end)
                begin
                    cmd.op     = bfa_pkg::OP_RD;
                    state_next = S_SH_WR;
                end
                else
                begin
                    cmd.op     = bfa_pkg::OP_FREE_END;
                    state_next = S_IDLE;
                end
            end
            S_SH_WR:
            begin
                cmd.op     = bfa_pkg::OP_SH_DN;
                state_next = S_SH_RD;
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

endmodule

@@ rtl/bfa_dpath.sv @@
// Datapath: block table memory, scan registers, counters and result register.
`timescale 1ns / 1ps
module bfa_dpath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bfa_pkg::cmd_t               cmd,
    output bfa_pkg::stat_t              st,
    input  logic [bfa_pkg::DATA_W-1:0]  cfg_data,
    input  logic                        in_opcode,
    input  logic [bfa_pkg::DATA_W-1:0]  in_size,
    input  logic [bfa_pkg::DATA_W-1:0]  in_release,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [bfa_pkg::DATA_W-1:0]  out_start,
    output logic [1:0]                  out_status
);

    localparam int DW = bfa_pkg::DATA_W;
    localparam int AW = bfa_pkg::AW;
    localparam int CW = bfa_pkg::CNT_W;

    logic [DW-1:0] total_reg;
    logic [CW-1:0] count_reg;
    logic [DW-1:0] reqcnt_reg;
    logic [DW-1:0] foc_reg;
    logic          free_op_reg;
    logic [DW-1:0] size_reg;
    logic [DW-1:0] rel_reg;
    logic [CW-1:0] idx_reg;
    logic          have_reg;
    logic          found_reg;
    logic [CW-1:0] best_idx_reg;
    logic [DW-1:0] best_start_reg;
    logic [DW-1:0] best_len_reg;
    logic [DW-1:0] best_tag_reg;
    logic          prev_free_reg;
    logic [DW-1:0] prev_start_reg;
    logic [DW-1:0] prev_len_reg;
    logic          right_free_reg;
    logic [DW-1:0] mlen_reg;
    logic [1:0]    rm_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [DW-1:0] out_start_reg;
    logic [1:0]    out_status_reg;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    bfa_pkg::entry_t             ram_wentry;
    logic [bfa_pkg::ENTRY_W-1:0] ram_rdata;
    bfa_pkg::entry_t             rd_e;
    logic [CW-1:0]               merge_pos;
    logic                        better;

    bfa_ram #(
        .WIDTH (bfa_pkg::ENTRY_W),
        .DEPTH (bfa_pkg::MAX_BLOCKS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_e      = bfa_pkg::entry_t'(ram_rdata);
    assign merge_pos = prev_free_reg ? (best_idx_reg - CW'(1)) : best_idx_reg;
    assign better    = !rd_e.used && (rd_e.length >= size_reg) &&
                       (!have_reg || (rd_e.length < best_len_reg) ||
                        ((rd_e.length == best_len_reg) && (rd_e.tag < best_tag_reg)));

    always_comb
    begin
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wentry = rd_e;
        case (cmd.op)
            bfa_pkg::OP_INIT:
            begin
                ram_we     = 1'b1;
                ram_wentry = '{start: DW'(1), length: total_reg, used: 1'b0, tag: '0};
            end
            bfa_pkg::OP_MERGE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = merge_pos[AW-1:0];
                ram_wentry = '{start: prev_free_reg ? prev_start_reg : best_start_reg,
                               length: prev_free_reg ? (prev_len_reg + mlen_reg) : mlen_reg,
                               used: 1'b0, tag: foc_reg + DW'(1)};
            end
            bfa_pkg::OP_SH_DN:
            begin
                ram_we    = 1'b1;
                ram_waddr = AW'(idx_reg - CW'(rm_reg));
            end
            bfa_pkg::OP_SH_UP:
            begin
                ram_we    = 1'b1;
                ram_waddr = AW'(idx_reg + CW'(1));
            end
            bfa_pkg::OP_WR_REM:
            begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(best_idx_reg + CW'(1));
                ram_wentry = '{start: best_start_reg + size_reg,
                               length: best_len_reg - size_reg,
                               used: 1'b0, tag: foc_reg + DW'(1)};
            end
            bfa_pkg::OP_WR_HEAD:
            begin
                ram_we     = 1'b1;
                ram_waddr  = best_idx_reg[AW-1:0];
                ram_wentry = '{start: best_start_reg, length: size_reg,
                               used: 1'b1, tag: reqcnt_reg};
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.op inside {bfa_pkg::OP_RES_OK, bfa_pkg::OP_RES_NOFIT, bfa_pkg::OP_RES_FULL})
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= DW'(1024);
            count_reg     <= CW'(1);
            reqcnt_reg    <= '0;
            foc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            case (cmd.op)
                bfa_pkg::OP_CFG:
                begin
                    total_reg <= cfg_data;
                end
                bfa_pkg::OP_INIT:
                begin
                    count_reg  <= CW'(1);
                    reqcnt_reg <= '0;
                    foc_reg    <= '0;
                end
                bfa_pkg::OP_ACCEPT:
                begin
                    reqcnt_reg <= reqcnt_reg + DW'(1);
                end
                bfa_pkg::OP_MERGE:
                begin
                    foc_reg <= foc_reg + DW'(1);
                end
                bfa_pkg::OP_FREE_END:
                begin
                    count_reg <= count_reg - CW'(rm_reg);
                end
                bfa_pkg::OP_WR_REM:
                begin
                    foc_reg   <= foc_reg + DW'(1);
                    count_reg <= count_reg + CW'(1);
                end
                default:
                begin
                    count_reg <= count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            bfa_pkg::OP_ACCEPT:
            begin
                free_op_reg    <= in_opcode;
                size_reg       <= in_size;
                rel_reg        <= in_release;
                idx_reg        <= '0;
                have_reg       <= 1'b0;
                found_reg      <= 1'b0;
                prev_free_reg  <= 1'b0;
                right_free_reg <= 1'b0;
            end
            bfa_pkg::OP_EV:
            begin
                idx_reg <= idx_reg + CW'(1);
                if (free_op_reg)
                begin
                    if (rd_e.used && (rd_e.tag == rel_reg))
                    begin
                        found_reg      <= 1'b1;
                        best_idx_reg   <= idx_reg;
                        best_start_reg <= rd_e.start;
                        mlen_reg       <= rd_e.length;
                    end
                    else
                    begin
                        prev_free_reg  <= !rd_e.used;
                        prev_start_reg <= rd_e.start;
                        prev_len_reg   <= rd_e.length;
                    end
                end
                else if (better)
                begin
                    have_reg       <= 1'b1;
                    best_idx_reg   <= idx_reg;
                    best_start_reg <= rd_e.start;
                    best_len_reg   <= rd_e.length;
                    best_tag_reg   <= rd_e.tag;
                end
            end
            bfa_pkg::OP_EV_RIGHT:
            begin
                right_free_reg <= !rd_e.used;
                if (!rd_e.used)
                begin
                    mlen_reg <= mlen_reg + rd_e.length;
                end
            end
            bfa_pkg::OP_MERGE:
            begin
                rm_reg  <= {1'b0, prev_free_reg} + {1'b0, right_free_reg};
                idx_reg <= best_idx_reg + CW'(1) + CW'(right_free_reg);
            end
            bfa_pkg::OP_SH_DN:
            begin
                idx_reg <= idx_reg + CW'(1);
            end
            bfa_pkg::OP_INS_START:
            begin
                idx_reg <= count_reg - CW'(1);
            end
            bfa_pkg::OP_SH_UP:
            begin
                idx_reg <= idx_reg - CW'(1);
            end
            bfa_pkg::OP_RES_OK:
            begin
                out_start_reg  <= best_start_reg;
                out_status_reg <= bfa_pkg::ST_OK;
            end
            bfa_pkg::OP_RES_NOFIT:
            begin
                out_start_reg  <= '0;
                out_status_reg <= bfa_pkg::ST_NOFIT;
            end
            bfa_pkg::OP_RES_FULL:
            begin
                out_start_reg  <= '0;
                out_status_reg <= bfa_pkg::ST_FULL;
            end
            default:
            begin
                idx_reg <= idx_reg;
            end
        endcase
    end

    assign st.is_free     = free_op_reg;
    assign st.found       = found_reg;
    assign st.scan_end    = (idx_reg >= count_reg);
    assign st.size_zero   = (size_reg == '0);
    assign st.have        = have_reg;
    assign st.rest_nz     = (best_len_reg != size_reg);
    assign st.full        = (count_reg == CW'(bfa_pkg::MAX_BLOCKS));
    assign st.idx_gt_best = (idx_reg > best_idx_reg);
    assign st.out_free    = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_start  = out_start_reg;
    assign out_status = out_status_reg;

endmodule

@@ rtl/bfa_checker.sv @@
// Port-level assertions for the best-fit allocator, bound to its top level.
`timescale 1ns / 1ps
`include "best_fit_allocator_coalescing_top_assert.svh"
module bfa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic [39:0] m_axis_tdata,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    `BFA_ASSERT_SAME(a_status_code, m_axis_tvalid, m_axis_tdata[33:32] != 2'd3, "bad status")
    `BFA_ASSERT_SAME(a_fail_zero, m_axis_tvalid && (m_axis_tdata[33:32] != 2'd0), m_axis_tdata[31:0] == 32'd0, "failed request with address")
    `BFA_ASSERT_NEXT(a_busy_after_req, s_axis_tvalid && s_axis_tready, !s_axis_tready && !cfg_ready, "ready while busy")
    `BFA_ASSERT_NEXT(a_busy_after_cfg, cfg_valid && cfg_ready, !s_axis_tready, "ready during rebuild")

endmodule

bind best_fit_allocator_coalescing_top bfa_checker u_bfa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready)
);

@@ bench/testbench.sv @@
// Testbench for the best-fit allocator with coalescing, checked against a built-in predictor.
`timescale 1ns / 1ps
module testbench;

    localparam int SETTLE_CYCLES = 4 * bfa_pkg::MAX_BLOCKS + 100;
    localparam int WATCHDOG_LIMIT = 5 * SETTLE_CYCLES;

    typedef struct packed {
        logic [31:0] start_address;
        logic [1:0]  status;
    } grant_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    logic [31:0] blk_start [bfa_pkg::MAX_BLOCKS];
    logic [31:0] blk_len [bfa_pkg::MAX_BLOCKS];
    logic [31:0] blk_tag [bfa_pkg::MAX_BLOCKS];
    bit          blk_used [bfa_pkg::MAX_BLOCKS];
    int unsigned blk_cnt;
    logic [31:0] seq_cnt;
    logic [31:0] free_order;
    logic [31:0] last_seq;
    bit          last_granted;

    grant_t      grant_q[$];
    logic [31:0] live_q[$];
    int          error_count = 0;
    int          idle_cycles = 0;
    int          hold_cycles = 0;
    bit          gaps_on;

    best_fit_allocator_coalescing_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic void table_init(logic [31:0] cells);
        blk_start[0] = 32'd1;
        blk_len[0] = cells;
        blk_used[0] = 1'b0;
        blk_tag[0] = 32'd0;
        blk_cnt = 1;
        seq_cnt = 32'd0;
        free_order = 32'd0;
    endfunction

    function automatic void drop_entry(int unsigned k);
        for (int unsigned i = k; i + 1 < blk_cnt; i++)
        begin
            blk_start[i] = blk_start[i + 1];
            blk_len[i] = blk_len[i + 1];
            blk_used[i] = blk_used[i + 1];
            blk_tag[i] = blk_tag[i + 1];
        end
        blk_cnt--;
    endfunction

    function automatic void release_block(logic [31:0] seq);
        int j;
        j = -1;
        for (int k = 0; k < blk_cnt; k++)
        begin
            if (j < 0 && blk_used[k] && blk_tag[k] == seq)
                j = k;
        end
        if (j < 0)
            return;
        blk_used[j] = 1'b0;
        if (j + 1 < blk_cnt && !blk_used[j + 1])
        begin
            blk_len[j] = blk_len[j] + blk_len[j + 1];
            drop_entry(j + 1);
        end
        if (j > 0 && !blk_used[j - 1])
        begin
            blk_len[j - 1] = blk_len[j - 1] + blk_len[j];
            drop_entry(j);
            j--;
        end
        free_order = free_order + 1;
        blk_tag[j] = free_order;
    endfunction

    function automatic grant_t best_fit(logic [31:0] size, logic [31:0] seq);
        grant_t r;
        int best;
        logic [31:0] rest;
        r.start_address = 32'd0;
        r.status = bfa_pkg::ST_NOFIT;
        best = -1;
        if (size == 0)
            return r;
        for (int k = 0; k < blk_cnt; k++)
        begin
            if (!blk_used[k] && blk_len[k] >= size)
            begin
                if (best < 0 || blk_len[k] < blk_len[best]
                    || (blk_len[k] == blk_len[best] && blk_tag[k] < blk_tag[best]))
                    best = k;
            end
        end
        if (best < 0)
            return r;
        rest = blk_len[best] - size;
        if (rest != 0 && blk_cnt >= bfa_pkg::MAX_BLOCKS)
        begin
            r.status = bfa_pkg::ST_FULL;
            return r;
        end
        if (rest != 0)
        begin
            for (int unsigned i = blk_cnt; i > best + 1; i--)
            begin
                blk_start[i] = blk_start[i - 1];
                blk_len[i] = blk_len[i - 1];
                blk_used[i] = blk_used[i - 1];
                blk_tag[i] = blk_tag[i - 1];
            end
            blk_cnt++;
            blk_start[best + 1] = blk_start[best] + size;
            blk_len[best + 1] = rest;
            blk_used[best + 1] = 1'b0;
            free_order = free_order + 1;
            blk_tag[best + 1] = free_order;
        end
        blk_len[best] = size;
        blk_used[best] = 1'b1;
        blk_tag[best] = seq;
        r.start_address = blk_start[best];
        r.status = bfa_pkg::ST_OK;
        return r;
    endfunction

    function automatic void predict_request(logic [71:0] req);
        grant_t g;
        seq_cnt = seq_cnt + 1;
        last_seq = seq_cnt;
        last_granted = 1'b0;
        if (req[0])
            release_block(req[64:33]);
        else
        begin
            g = best_fit(req[32:1], seq_cnt);
            last_granted = (g.status == bfa_pkg::ST_OK);
            grant_q = {grant_q, g};
        end
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (!gaps_on || roll < 40)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_request(logic op, logic [31:0] size, logic [31:0] rel);
        int gap;
        logic [71:0] req;
        gap = pick_gap();
        req = {7'd0, rel, size, op};
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= req;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_request(req);
    endtask

    task automatic alloc(logic [31:0] size);
        send_request(1'b0, size, $urandom);
    endtask

    task automatic release_seq(logic [31:0] seq);
        send_request(1'b1, $urandom, seq);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (grant_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cells(logic [31:0] cells);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= cells;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        table_init(cells);
        live_q.delete();
    endtask

    task automatic test_default_store();
        alloc(32'd0);
        alloc(32'd2000);
        alloc(32'd100);
        alloc(32'd50);
        alloc(32'd100);
        alloc(32'd50);
        alloc(32'd10);
        release_seq(32'd3);
        release_seq(32'd5);
        alloc(32'd100);
        release_seq(32'd3);
        release_seq(32'hFFFF_FFFF);
        release_seq(32'd1);
        release_seq(32'd4);
        release_seq(32'd6);
        alloc(32'd724);
        alloc(32'd1);
        release_seq(32'd7);
    endtask

    task automatic test_wide_and_empty();
        write_cells(32'hFFFF_FFFF);
        alloc(32'hFFFF_FFFF);
        release_seq(32'd1);
        alloc(32'hFFFF_FFFE);
        alloc(32'd1);
        alloc(32'd1);
        write_cells(32'd0);
        alloc(32'd1);
        alloc(32'd0);
        write_cells(32'd1);
        alloc(32'd1);
        alloc(32'd1);
    endtask

    task automatic test_random_traffic();
        logic [31:0] cells;
        int idx;
        int roll;
        write_cells(32'd1024);
        for (int n = 0; n < 260; n++)
        begin
            if (n == 90 || n == 180)
            begin
                cells = $urandom_range(1, 4096);
                write_cells(cells);
            end
            if (n % 60 == 30)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                while (grant_q.size() != 0)
                    @(posedge clk);
            end
            roll = $urandom_range(0, 99);
            if (roll < 50)
            begin
                alloc($urandom_range(0, 99) < 90 ? $urandom_range(1, 64) : $urandom);
                if (last_granted)
                    live_q = {live_q, last_seq};
            end
            else if (roll < 88 && live_q.size() != 0)
            begin
                idx = $urandom_range(0, live_q.size() - 1);
                release_seq(live_q[idx]);
                live_q.delete(idx);
            end
            else if (roll < 94)
                release_seq($urandom);
            else
                release_seq(seq_cnt - $urandom_range(0, 5));
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
            hold_cycles <= hold_cycles - 1;
        else
        begin
            m_axis_tready <= ($urandom_range(0, 2) != 0);
            hold_cycles <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 3);
        end
    end

    always @(posedge clk)
    begin
        grant_t g;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (grant_q.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result %h", $time, m_axis_tdata[33:0]);
            end
            else
            begin
                g = grant_q.pop_front();
                if (m_axis_tdata[31:0] !== g.start_address)
                begin
                    error_count++;
                    $display("%0t: start_address expected %h actual %h",
                             $time, g.start_address, m_axis_tdata[31:0]);
                end
                if (m_axis_tdata[33:32] !== g.status)
                begin
                    error_count++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, g.status, m_axis_tdata[33:32]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        gaps_on = 1'b1;
        table_init(32'd1024);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_default_store();
        test_wide_and_empty();
        test_random_traffic();
        drain();
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ best_fit_allocator_coalescing_top.f @@
+incdir+rtl
rtl/bfa_pkg.sv
rtl/bfa_ram.sv
rtl/bfa_ctrl.sv
rtl/bfa_dpath.sv
rtl/best_fit_allocator_coalescing_top.sv
rtl/bfa_checker.sv
bench/testbench.sv
